// File: rtl/core/hsfb_pkg.sv
package hsfb_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  ESC_FLAG    = 8'h5E;
    localparam logic [7:0]  ESC_ESC     = 8'h5D;
    localparam logic [11:0] RESET_LIMIT = 12'd1024;

    localparam logic ACTION_SUPERVISORY = 1'b0;
    localparam logic ACTION_DATA        = 1'b1;

    // one classified transaction, as handed from the front to the back
    typedef struct packed {
        logic       hdr;
        logic [7:0] address;
        logic [7:0] control;
        logic       has_data;
        logic [7:0] data;
        logic       err;
        logic       has_check;
        logic [7:0] check;
        logic       close;
    } job_t;

    function automatic logic needs_stuff(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    function automatic logic [7:0] stuff_second(input logic [7:0] b);
        return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    endfunction

endpackage

// File: rtl/core/hsfb_front.sv
module hsfb_front import hsfb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        accept,
    input  logic        action,
    input  logic [7:0]  address,
    input  logic [7:0]  control,
    input  logic [7:0]  data_byte,
    input  logic        last_data,
    output logic        push,
    output job_t        job
);

    logic [11:0] max_len_reg;
    logic        in_frame_reg, in_frame_next;
    logic        dropping_reg, dropping_next;
    logic [7:0]  check_reg, check_next;
    logic [11:0] count_reg, count_next;

    logic [11:0] base_count;
    logic [7:0]  base_check;
    logic [12:0] stuffed_len;
    logic [12:0] total;
    logic        over;

    assign base_count  = in_frame_reg ? count_reg : 12'd0;
    assign base_check  = in_frame_reg ? check_reg : 8'd0;
    assign stuffed_len = needs_stuff(data_byte) ? 13'd2 : 13'd1;
    assign total       = {1'b0, base_count} + stuffed_len;
    assign over        = total > {1'b0, max_len_reg};

    always_comb begin
        in_frame_next = in_frame_reg;
        dropping_next = dropping_reg;
        check_next    = check_reg;
        count_next    = count_reg;
        push          = 1'b0;
        job           = '0;
        job.address   = address;
        job.control   = control;
        job.data      = data_byte;
        if (accept) begin
            if (action == ACTION_SUPERVISORY) begin
                // abandons any open frame
                in_frame_next = 1'b0;
                dropping_next = 1'b0;
                check_next    = 8'd0;
                count_next    = 12'd0;
                push          = 1'b1;
                job.hdr       = 1'b1;
                job.close     = 1'b1;
            end else if (dropping_reg) begin
                if (last_data) begin
                    in_frame_next = 1'b0;
                    dropping_next = 1'b0;
                    check_next    = 8'd0;
                    count_next    = 12'd0;
                end
            end else begin
                push    = 1'b1;
                job.hdr = !in_frame_reg;
                if (over) begin
                    job.err       = 1'b1;
                    in_frame_next = !last_data;
                    dropping_next = !last_data;
                    check_next    = 8'd0;
                    count_next    = 12'd0;
                end else begin
                    job.has_data  = 1'b1;
                    in_frame_next = 1'b1;
                    count_next    = total[11:0];
                    check_next    = base_check ^ data_byte;
                    if (last_data) begin
                        job.has_check = 1'b1;
                        job.check     = base_check ^ data_byte;
                        job.close     = 1'b1;
                        in_frame_next = 1'b0;
                        check_next    = 8'd0;
                        count_next    = 12'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg  <= RESET_LIMIT;
            in_frame_reg <= 1'b0;
            dropping_reg <= 1'b0;
            check_reg    <= 8'd0;
            count_reg    <= 12'd0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            in_frame_reg <= in_frame_next;
            dropping_reg <= dropping_next;
            check_reg    <= check_next;
            count_reg    <= count_next;
        end
    end

endmodule

// File: rtl/core/hsfb_queue.sv
module hsfb_queue import hsfb_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t wr_job,
    input  logic pop,
    output job_t rd_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full   = count_reg == CNT_W'(DEPTH);
    assign empty  = count_reg == '0;
    assign rd_job = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/hsfb_back.sv
module hsfb_back import hsfb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       rd_job,
    input  logic       empty,
    output logic       pop,
    input  logic       m_ready,
    output logic       m_valid,
    output logic [7:0] m_out_byte,
    output logic       m_run_end,
    output logic       m_frame_done,
    output logic       m_overflow_error
);

    typedef enum logic [2:0] {
        ST_FLAG0 = 3'd0,
        ST_ADDR  = 3'd1,
        ST_CTRL  = 3'd2,
        ST_BCC   = 3'd3,
        ST_DATA  = 3'd4,
        ST_ERR   = 3'd5,
        ST_CHECK = 3'd6,
        ST_CLOSE = 3'd7
    } step_t;

    job_t       job_reg;
    logic       job_valid_reg;
    step_t      step_reg;
    logic       half_reg;
    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_run_end_reg;
    logic       m_frame_done_reg;
    logic       m_overflow_error_reg;

    logic [7:0] cur_mask, new_mask;
    logic [3:0] nxt, first;
    logic [7:0] src_byte;
    logic       src_stuff;
    logic       hold_step;
    logic       job_end;
    logic       load;
    logic [7:0] byte_next;
    logic       done_next;
    logic       err_next;

    // lowest enabled step at or above start; msb flags a hit
    function automatic logic [3:0] find_from(input logic [7:0] mask, input logic [3:0] start);
        logic [3:0] res;
        res = 4'd0;
        for (int i = 7; i >= 0; i--) begin
            if (i >= int'(start) && mask[i]) begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] step_mask(input job_t j);
        return {j.close, j.has_check, j.err, j.has_data, {4{j.hdr}}};
    endfunction

    assign cur_mask = step_mask(job_reg);
    assign new_mask = step_mask(rd_job);
    assign nxt      = find_from(cur_mask, {1'b0, step_reg} + 4'd1);
    assign first    = find_from(new_mask, 4'd0);

    assign src_byte  = (step_reg == ST_CHECK) ? job_reg.check : job_reg.data;
    assign src_stuff = needs_stuff(src_byte);

    always_comb begin
        byte_next = FLAG_BYTE;
        done_next = 1'b0;
        err_next  = 1'b0;
        hold_step = 1'b0;
        case (step_reg)
            ST_FLAG0: byte_next = FLAG_BYTE;
            ST_ADDR:  byte_next = job_reg.address;
            ST_CTRL:  byte_next = job_reg.control;
            ST_BCC:   byte_next = job_reg.address ^ job_reg.control;
            ST_DATA, ST_CHECK: begin
                // escaped bytes go out as two transactions
                if (src_stuff && !half_reg) begin
                    byte_next = ESC_BYTE;
                    hold_step = 1'b1;
                end else if (src_stuff) begin
                    byte_next = stuff_second(src_byte);
                end else begin
                    byte_next = src_byte;
                end
            end
            ST_ERR: begin
                byte_next = 8'd0;
                err_next  = 1'b1;
            end
            ST_CLOSE: begin
                byte_next = FLAG_BYTE;
                done_next = 1'b1;
            end
            default: byte_next = FLAG_BYTE;
        endcase
    end

    assign job_end = !hold_step && !nxt[3];
    assign load    = job_valid_reg && (!m_valid_reg || m_ready);
    assign pop     = !empty && (!job_valid_reg || (load && job_end));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop) begin
                job_valid_reg <= 1'b1;
                half_reg      <= 1'b0;
            end else if (load) begin
                if (job_end) begin
                    job_valid_reg <= 1'b0;
                end
                half_reg <= hold_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_out_byte_reg       <= byte_next;
            m_run_end_reg        <= job_end;
            m_frame_done_reg     <= done_next;
            m_overflow_error_reg <= err_next;
        end
        if (pop) begin
            job_reg  <= rd_job;
            step_reg <= step_t'(first[2:0]);
        end else if (load && !hold_step) begin
            step_reg <= step_t'(nxt[2:0]);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = m_out_byte_reg;
    assign m_run_end        = m_run_end_reg;
    assign m_frame_done     = m_frame_done_reg;
    assign m_overflow_error = m_overflow_error_reg;

endmodule

// File: rtl/core/hdlc_style_frame_builder.sv
// path: first line byte goes via the job queue, the emitter job register and output register
// throughput: one line byte per cycle while m_ready is high; a transaction produces one
// line byte per plain data byte, two when escaped, up to 9; the emitter sets the rate
// input accepted every cycle while the job queue has room
// reset: synchronous active-low aresetn clears frame state, queue and output valid;
// the payload length limit returns to 1024
module hdlc_style_frame_builder import hsfb_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_address,
    input  logic [7:0]  s_control,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_end,
    output logic        m_frame_done,
    output logic        m_overflow_error
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t wr_job;
    job_t rd_job;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    hsfb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .action      (s_action),
        .address     (s_address),
        .control     (s_control),
        .data_byte   (s_data_byte),
        .last_data   (s_last_data),
        .push        (push),
        .job         (wr_job)
    );

    hsfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (wr_job),
        .pop     (pop),
        .rd_job  (rd_job),
        .full    (full),
        .empty   (empty)
    );

    hsfb_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .rd_job           (rd_job),
        .empty            (empty),
        .pop              (pop),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_out_byte       (m_out_byte),
        .m_run_end        (m_run_end),
        .m_frame_done     (m_frame_done),
        .m_overflow_error (m_overflow_error)
    );

endmodule
